### design/triangle_azimuth_sector_select_macros.svh
// assertion macros for the triangle azimuth sector select block
// used by the top level only
`ifndef TRIANGLE_AZIMUTH_SECTOR_SELECT_MACROS_SVH
`define TRIANGLE_AZIMUTH_SECTOR_SELECT_MACROS_SVH
`define TASS_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define TASS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### design/tass_pkg.sv
// shared types and constants for the triangle azimuth sector select block
// no dependencies
package tass_pkg;
  localparam int unsigned NumRegs = 7;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned BoundBits = 16;
  localparam int unsigned AccBits = 32;
  localparam int unsigned NumVerts = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    RegCenterX = 3'd0,
    RegCenterZ = 3'd1,
    RegBoundOne = 3'd2,
    RegBoundTwo = 3'd3,
    RegBoundThree = 3'd4,
    RegBoundFour = 3'd5,
    RegBoundFive = 3'd6
  } reg_idx_e;

  localparam logic [BoundBits-1:0] BoundOneRst = 16'd14564;
  localparam logic [BoundBits-1:0] BoundTwoRst = 16'd27307;
  localparam logic [BoundBits-1:0] BoundThreeRst = 16'd38411;
  localparam logic [BoundBits-1:0] BoundFourRst = 16'd51883;
  localparam logic [BoundBits-1:0] BoundFiveRst = 16'd62805;

  typedef struct packed {
    logic [BoundBits-1:0] b1;
    logic [BoundBits-1:0] b2;
    logic [BoundBits-1:0] b3;
    logic [BoundBits-1:0] b4;
    logic [BoundBits-1:0] b5;
  } bounds_t;

  function automatic logic [AccBits-1:0] atan_turn(input int unsigned i);
    logic [AccBits-1:0] t;
    begin
      case (i)
        0: t = 32'h20000000;  1: t = 32'h12E4051E;
        2: t = 32'h09FB385B;  3: t = 32'h051111D4;
        4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E;  7: t = 32'h00517C55;
        8: t = 32'h0028BE53;  9: t = 32'h00145F2F;
        10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3;
        14: t = 32'h0000A2FA; 15: t = 32'h0000517D;
        16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A30; 19: t = 32'h00000518;
        20: t = 32'h0000028C; 21: t = 32'h00000146;
        22: t = 32'h000000A3; 23: t = 32'h00000051;
        default: t = '0;
      endcase
      return t;
    end
  endfunction
endpackage

### design/tass_if.sv
// valid/ready channel interfaces for the sector select block
// depends on tass_pkg
interface tass_in_if #(parameter int unsigned COORD_BITS = 24);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] vert_a_x, vert_a_z, vert_b_x, vert_b_z, vert_c_x, vert_c_z;
  logic last_triangle;
  modport source (output valid, vert_a_x, vert_a_z, vert_b_x, vert_b_z, vert_c_x,
                  vert_c_z, last_triangle, input ready);
  modport sink (input valid, vert_a_x, vert_a_z, vert_b_x, vert_b_z, vert_c_x,
                vert_c_z, last_triangle, output ready);
endinterface

interface tass_out_if;
  logic valid;
  logic ready;
  logic [4:0] sector_mask;
  logic last_out;
  modport source (output valid, sector_mask, last_out, input ready);
  modport sink (input valid, sector_mask, last_out, output ready);
endinterface

interface tass_cfg_if #(parameter int unsigned COORD_BITS = 24);
  logic valid;
  logic ready;
  logic [tass_pkg::CfgIdxBits-1:0] index;
  logic [COORD_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/triangle_azimuth_sector_select.sv
// throughput: one triangle per cycle while the skid register is empty, three azimuth pipelines run side by side
// a stall of the output freezes the whole pipeline, a skid register keeps ready registered
// reset clears valid bits and loads centre 0 and the default sector bounds
// depends on tass_pkg, tass_if, tass_azimuth, tass_sector and the macro header
`include "triangle_azimuth_sector_select_macros.svh"
module triangle_azimuth_sector_select #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  tass_in_if.sink in_if,
  tass_out_if.source out_if,
  tass_cfg_if.sink cfg_if
);
  localparam int unsigned LAT = ((CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES) + 2;

  logic signed [COORD_BITS-1:0] cx_q, cz_q;
  tass_pkg::bounds_t bnd_q;

  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cz_q <= '0;
      bnd_q <= {tass_pkg::BoundOneRst, tass_pkg::BoundTwoRst, tass_pkg::BoundThreeRst,
                tass_pkg::BoundFourRst, tass_pkg::BoundFiveRst};
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        tass_pkg::RegCenterX: cx_q <= cfg_if.data;
        tass_pkg::RegCenterZ: cz_q <= cfg_if.data;
        tass_pkg::RegBoundOne: bnd_q.b1 <= cfg_if.data[15:0];
        tass_pkg::RegBoundTwo: bnd_q.b2 <= cfg_if.data[15:0];
        tass_pkg::RegBoundThree: bnd_q.b3 <= cfg_if.data[15:0];
        tass_pkg::RegBoundFour: bnd_q.b4 <= cfg_if.data[15:0];
        tass_pkg::RegBoundFive: bnd_q.b5 <= cfg_if.data[15:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the skid register is full
  logic en;
  logic out_valid_q;
  logic [4:0] out_mask_q;
  logic out_last_q;
  logic pipe_valid;
  logic [4:0] pipe_mask;
  logic pipe_last;
  logic skid_valid_q;
  logic [4:0] skid_mask_q;
  logic skid_last_q;

  assign en = !skid_valid_q;
  assign in_if.ready = en;

  logic signed [COORD_BITS-1:0] px [tass_pkg::NumVerts];
  logic signed [COORD_BITS-1:0] pz [tass_pkg::NumVerts];
  logic [ANGLE_BITS-1:0] ang [tass_pkg::NumVerts];
  logic [tass_pkg::NumVerts-1:0] av;
  assign px[0] = in_if.vert_a_x; assign pz[0] = in_if.vert_a_z;
  assign px[1] = in_if.vert_b_x; assign pz[1] = in_if.vert_b_z;
  assign px[2] = in_if.vert_c_x; assign pz[2] = in_if.vert_c_z;

  for (genvar k = 0; k < tass_pkg::NumVerts; k++) begin : g_az
    tass_azimuth #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS),
                   .CORDIC_STAGES(CORDIC_STAGES)) u_az (
      .clk_i, .rst_ni, .en_i(en), .valid_i(in_if.valid),
      .px_i(px[k]), .pz_i(pz[k]), .cx_i(cx_q), .cz_i(cz_q),
      .valid_o(av[k]), .angle_o(ang[k])
    );
  end

  logic [LAT-1:0] last_pipe_q;
  always_ff @(posedge clk_i) begin
    if (en) last_pipe_q <= {last_pipe_q[LAT-2:0], in_if.last_triangle};
  end

  logic sv_q;
  logic sl_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q <= 1'b0;
    else if (en) sv_q <= av[0];
  end
  always_ff @(posedge clk_i) begin
    if (en) sl_q <= last_pipe_q[LAT-1];
  end

  tass_sector #(.ANGLE_BITS(ANGLE_BITS)) u_sector (
    .clk_i, .en_i(en), .ang_i(ang), .bounds_i(bnd_q), .mask_o(pipe_mask)
  );
  assign pipe_valid = sv_q;
  assign pipe_last = sl_q;

  // output register with skid stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_if.ready) begin
        out_valid_q <= skid_valid_q || pipe_valid;
        skid_valid_q <= 1'b0;
      end else if (en && pipe_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_if.ready) begin
      out_mask_q <= skid_valid_q ? skid_mask_q : pipe_mask;
      out_last_q <= skid_valid_q ? skid_last_q : pipe_last;
    end else if (en && pipe_valid) begin
      skid_mask_q <= pipe_mask;
      skid_last_q <= pipe_last;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.sector_mask = out_mask_q;
  assign out_if.last_out = out_last_q;

  `TASS_ASSERT_IMPL(a_lanes_aligned, clk_i, rst_ni, 1'b1, (av[0] == av[1]) && (av[1] == av[2]))
  `TASS_ASSERT_IMPL(a_skid_needs_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `TASS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_if.ready,
                    out_valid_q && $stable(out_mask_q))
endmodule

### design/tass_cordic_stage.sv
// one registered cordic vectoring stage with valid bit
// depends on tass_pkg
module tass_cordic_stage #(
  parameter int unsigned W = 34,
  parameter int unsigned SHIFT = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic [tass_pkg::AccBits-1:0] acc_i,
  output logic valid_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic [tass_pkg::AccBits-1:0] acc_o
);
  logic signed [W-1:0] x_d, y_d;
  logic [tass_pkg::AccBits-1:0] acc_d;
  logic valid_q;

  always_comb begin
    if (!y_i[W-1]) begin
      x_d = x_i + (y_i >>> SHIFT);
      y_d = y_i - (x_i >>> SHIFT);
      acc_d = acc_i + tass_pkg::atan_turn(SHIFT);
    end else begin
      x_d = x_i - (y_i >>> SHIFT);
      y_d = y_i + (x_i >>> SHIFT);
      acc_d = acc_i - tass_pkg::atan_turn(SHIFT);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (en_i) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      acc_o <= acc_d;
    end
  end

  assign valid_o = valid_q;
endmodule

### design/tass_azimuth.sv
// pipelined azimuth unit: centre offset, prerotation, cordic stages, rounding
// depends on tass_pkg and tass_cordic_stage
module tass_azimuth #(
  parameter int unsigned COORD_BITS = 24,
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] pz_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cz_i,
  output logic valid_o,
  output logic [ANGLE_BITS-1:0] angle_o
);
  // coordinates scaled by 256 plus cordic growth
  localparam int unsigned W = COORD_BITS + 12;
  localparam int unsigned NS = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
  localparam int unsigned AB = tass_pkg::AccBits;

  logic signed [COORD_BITS:0] dx_d, dz_d;
  logic signed [COORD_BITS:0] dx_q, dz_q;
  logic v0_q;
  logic signed [W-1:0] x0, y0;
  logic [AB-1:0] acc0;
  logic zero0;

  assign dx_d = $signed({px_i[COORD_BITS-1], px_i}) - $signed({cx_i[COORD_BITS-1], cx_i});
  assign dz_d = $signed({pz_i[COORD_BITS-1], pz_i}) - $signed({cz_i[COORD_BITS-1], cz_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en_i) v0_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= dx_d;
      dz_q <= dz_d;
    end
  end

  always_comb begin
    logic signed [W-1:0] xs, ys;
    xs = W'(dz_q) <<< 8;
    ys = W'(dx_q) <<< 8;
    zero0 = (dx_q == '0) && (dz_q == '0);
    if (dz_q[COORD_BITS]) begin
      x0 = -xs;
      y0 = -ys;
      acc0 = {1'b1, {(AB-1){1'b0}}};
    end else begin
      x0 = xs;
      y0 = ys;
      acc0 = '0;
    end
  end

  logic signed [W-1:0] xs_w [NS+1];
  logic signed [W-1:0] ys_w [NS+1];
  logic [AB-1:0] acc_w [NS+1];
  logic vs_w [NS+1];
  logic [NS:0] zero_q;

  assign xs_w[0] = x0;
  assign ys_w[0] = y0;
  assign acc_w[0] = acc0;
  assign vs_w[0] = v0_q;
  assign zero_q[0] = zero0;

  for (genvar i = 0; i < NS; i++) begin : g_stage
    tass_cordic_stage #(.W(W), .SHIFT(i)) u_stage (
      .clk_i, .rst_ni, .en_i,
      .valid_i(vs_w[i]), .x_i(xs_w[i]), .y_i(ys_w[i]), .acc_i(acc_w[i]),
      .valid_o(vs_w[i+1]), .x_o(xs_w[i+1]), .y_o(ys_w[i+1]), .acc_o(acc_w[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en_i) zero_q[i+1] <= zero_q[i];
    end
  end

  logic [AB-1:0] rnd;
  logic [ANGLE_BITS-1:0] angle_q;
  logic vout_q;
  assign rnd = acc_w[NS] + (AB'(1) << (AB - 1 - ANGLE_BITS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vout_q <= 1'b0;
    else if (en_i) vout_q <= vs_w[NS];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) angle_q <= zero_q[NS] ? '0 : rnd[AB-1 -: ANGLE_BITS];
  end

  assign valid_o = vout_q;
  assign angle_o = angle_q;
endmodule

### design/tass_sector.sv
// registered sector rule evaluation on three azimuths
// depends on tass_pkg
module tass_sector #(
  parameter int unsigned ANGLE_BITS = 16
) (
  input  logic clk_i,
  input  logic en_i,
  input  logic [ANGLE_BITS-1:0] ang_i [tass_pkg::NumVerts],
  input  tass_pkg::bounds_t bounds_i,
  output logic [4:0] mask_o
);
  // compare on a common 24-bit scale
  localparam int unsigned CW = 24;
  logic [CW-1:0] a [tass_pkg::NumVerts];
  logic [CW-1:0] b1, b2, b3, b4, b5;
  logic [4:0] mask_d;

  always_comb begin
    logic lt5, ge4all, lt1, gt5, gt1, le2, ge3, le4, ge2, le3;
    b1 = CW'(bounds_i.b1) << 8;
    b2 = CW'(bounds_i.b2) << 8;
    b3 = CW'(bounds_i.b3) << 8;
    b4 = CW'(bounds_i.b4) << 8;
    b5 = CW'(bounds_i.b5) << 8;
    lt5 = 1'b0; ge4all = 1'b1; lt1 = 1'b0; gt5 = 1'b0; gt1 = 1'b0;
    le2 = 1'b0; ge3 = 1'b0; le4 = 1'b0; ge2 = 1'b0; le3 = 1'b0;
    for (int k = 0; k < tass_pkg::NumVerts; k++) begin
      a[k] = CW'(ang_i[k]) << (24 - ANGLE_BITS);
      lt5 |= a[k] < b5;
      ge4all &= a[k] >= b4;
      lt1 |= a[k] < b1;
      gt5 |= a[k] > b5;
      gt1 |= a[k] > b1;
      le2 |= a[k] <= b2;
      ge3 |= a[k] >= b3;
      le4 |= a[k] <= b4;
      ge2 |= a[k] >= b2;
      le3 |= a[k] <= b3;
    end
    mask_d = {ge2 && le3, ge3 && le4, gt1 && le2, lt1 || gt5, lt5 && ge4all};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) mask_o <= mask_d;
  end
endmodule
